@@ hw/rtl/kftt_pkg.sv @@
// shared types and constants for the key frequency tracking table
package kftt_pkg;

	localparam int CANDIDATES  = 64;
	localparam int KEY_ATTRS   = 4;
	localparam int FIELD_ATTRS = 4;
	localparam int ATTR_W      = 15;
	localparam int KEY_W       = ATTR_W * FIELD_ATTRS;
	localparam int IDX_W       = 6;
	localparam int USED_W      = 7;
	localparam int FREQ_W      = 31;
	localparam int ROWS_W      = 48;
	localparam logic [ROWS_W-1:0] MIN_ROWS_RESET = 48'd1000;
	localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

	localparam logic OP_TRACK  = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [2:0] ST_HIT       = 3'd0;
	localparam logic [2:0] ST_ADDED     = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_BAD_COUNT = 3'd3;
	localparam logic [2:0] ST_TOO_SMALL = 3'd4;
	localparam logic [2:0] ST_INDEXED   = 3'd5;
	localparam logic [2:0] ST_REMOVED   = 3'd6;
	localparam logic [2:0] ST_BAD_POS   = 3'd7;

	typedef struct packed {
		logic              opcode;
		logic [31:0]       relation_id;
		logic [2:0]        attr_count;
		logic [ATTR_W-1:0] attr_a;
		logic [ATTR_W-1:0] attr_b;
		logic [ATTR_W-1:0] attr_c;
		logic [ATTR_W-1:0] attr_d;
		logic [ROWS_W-1:0] row_estimate;
		logic              already_indexed;
		logic [IDX_W-1:0]  position;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [IDX_W-1:0]  slot;
		logic [FREQ_W-1:0] frequency;
		logic [USED_W-1:0] entries_used;
	} rsp_t;

	typedef struct packed {
		logic [31:0]       relation;
		logic [2:0]        attr_count;
		logic [KEY_W-1:0]  attrs;
		logic [FREQ_W-1:0] frequency;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ hw/rtl/key_frequency_tracking_table.sv @@
// key frequency tracking table: scan, hit count, append and remove with shift-down
// rejects and bad positions give their result straight from the prep state; a track request
// scans the entries in order and a remove shifts each later entry down, one ram read per cycle
// throughput: one request at a time, the next accepted in the cycle after the result is loaded
// reset: asynchronous, empties the table and sets min_rows to 1000; entry ram not cleared
module key_frequency_tracking_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  kftt_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output kftt_pkg::rsp_t                rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kftt_pkg::ROWS_W-1:0]   cfg_data
);
	import kftt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PREP  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_SHIFT = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	req_t              req_q;
	logic [ROWS_W-1:0] min_rows_q;
	logic [USED_W-1:0] used_q, used_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [KEY_W-1:0]  key_c, key_q;
	logic [2:0]        res_status_q, res_status_d;
	logic [IDX_W-1:0]  res_slot_q, res_slot_d;
	logic [FREQ_W-1:0] res_freq_q, res_freq_d;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              wr_en, rd_en;
	logic [IDX_W-1:0]  wr_addr, rd_addr;
	entry_t            wr_data, rd_data;
	logic              hit;
	logic [USED_W-1:0] pos_ext;
	logic              rsp_free;

	kftt_sort u_sort (.req(req_q), .key(key_c));

	kftt_ram #(.WIDTH(ENTRY_W), .DEPTH(CANDIDATES)) u_ram (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
	);

	assign req_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign pos_ext   = {1'b0, req_q.position};

	assign hit = (rd_data.relation == req_q.relation_id) &&
		(rd_data.attr_count == req_q.attr_count) && (rd_data.attrs == key_q);

	always_comb begin
		state_d      = state_q;
		used_d       = used_q;
		idx_d        = idx_q;
		res_status_d = res_status_q;
		res_slot_d   = res_slot_q;
		res_freq_d   = res_freq_q;
		wr_en        = 1'b0;
		wr_addr      = idx_q;
		wr_data      = rd_data;
		rd_en        = 1'b0;
		rd_addr      = idx_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				state_d      = S_DONE;
				res_slot_d   = '0;
				res_freq_d   = '0;
				if (req_q.opcode == OP_REMOVE) begin
					if (pos_ext >= used_q) begin
						res_status_d = ST_BAD_POS;
					end else begin
						res_status_d = ST_REMOVED;
						res_slot_d   = req_q.position;
						if (pos_ext + 7'd1 < used_q) begin
							rd_en   = 1'b1;
							rd_addr = req_q.position + 6'd1;
							idx_d   = req_q.position;
							state_d = S_SHIFT;
						end else begin
							used_d = used_q - 7'd1;
						end
					end
				end else if (req_q.attr_count == 3'd0 || 32'(req_q.attr_count) > KEY_ATTRS ||
						32'(req_q.attr_count) > FIELD_ATTRS) begin
					res_status_d = ST_BAD_COUNT;
				end else if (req_q.row_estimate < min_rows_q) begin
					res_status_d = ST_TOO_SMALL;
				end else if (req_q.already_indexed) begin
					res_status_d = ST_INDEXED;
				end else if (used_q == '0) begin
					// empty table: append at once
					wr_en        = 1'b1;
					wr_addr      = '0;
					wr_data      = '{req_q.relation_id, req_q.attr_count, key_c, FREQ_W'(1)};
					used_d       = 7'd1;
					res_status_d = ST_ADDED;
					res_freq_d   = FREQ_W'(1);
				end else begin
					rd_en   = 1'b1;
					rd_addr = '0;
					idx_d   = '0;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// rd_data holds the entry at idx_q
				if (hit) begin
					wr_en   = 1'b1;
					wr_addr = idx_q;
					wr_data = rd_data;
					if (rd_data.frequency != FREQ_MAX) begin
						wr_data.frequency = rd_data.frequency + FREQ_W'(1);
					end
					res_status_d = ST_HIT;
					res_slot_d   = idx_q;
					res_freq_d   = wr_data.frequency;
					state_d      = S_DONE;
				end else if ({1'b0, idx_q} + 7'd1 == used_q) begin
					state_d = S_DONE;
					if (used_q == USED_W'(CANDIDATES)) begin
						res_status_d = ST_FULL;
					end else begin
						wr_en        = 1'b1;
						wr_addr      = used_q[IDX_W-1:0];
						wr_data      = '{req_q.relation_id, req_q.attr_count, key_q,
							FREQ_W'(1)};
						used_d       = used_q + 7'd1;
						res_status_d = ST_ADDED;
						res_slot_d   = used_q[IDX_W-1:0];
						res_freq_d   = FREQ_W'(1);
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_q + 6'd1;
					idx_d   = idx_q + 6'd1;
				end
			end
			S_SHIFT: begin
				// move entry idx_q+1 down into idx_q
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = rd_data;
				if ({1'b0, idx_q} + 7'd2 < used_q) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + 6'd2;
					idx_d   = idx_q + 6'd1;
				end else begin
					used_d  = used_q - 7'd1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			min_rows_q  <= MIN_ROWS_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			if (cfg_valid && cfg_ready) begin
				min_rows_q <= cfg_data;
			end
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == S_PREP) begin
			key_q <= key_c;
		end
		idx_q        <= idx_d;
		res_status_q <= res_status_d;
		res_slot_q   <= res_slot_d;
		res_freq_q   <= res_freq_d;
		if (state_q == S_DONE && rsp_free) begin
			rsp_q <= '{res_status_q, res_slot_q, res_freq_q, used_q};
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(CANDIDATES))
		else $error("entry count above table size");
	a_added_freq: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_ADDED |-> rsp.frequency == FREQ_W'(1) &&
		rsp.entries_used == USED_W'(rsp.slot) + 7'd1)
		else $error("added beat inconsistent");
	a_hit_freq: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_HIT |-> rsp.frequency != '0)
		else $error("hit beat with zero frequency");
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == S_PREP || state_q == S_SCAN || state_q == S_SHIFT)
		else $error("ram write outside working states");
endmodule

@@ hw/rtl/kftt_ram.sv @@
// generic simple dual port ram, one write and one registered read
module kftt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

@@ hw/rtl/kftt_sort.sv @@
// sorts the valid attributes of a request ascending and packs the key
module kftt_sort (
	input  kftt_pkg::req_t              req,
	output logic [kftt_pkg::KEY_W-1:0]  key
);
	import kftt_pkg::*;

	// invalid attributes carry a high tag bit so they sink to the end
	logic [ATTR_W:0] v0 [FIELD_ATTRS];
	logic [ATTR_W:0] v1 [FIELD_ATTRS];
	logic [ATTR_W:0] v2 [FIELD_ATTRS];
	logic [ATTR_W:0] v3 [FIELD_ATTRS];

	always_comb begin
		v0[0] = {(req.attr_count <= 3'd0), req.attr_a};
		v0[1] = {(req.attr_count <= 3'd1), req.attr_b};
		v0[2] = {(req.attr_count <= 3'd2), req.attr_c};
		v0[3] = {(req.attr_count <= 3'd3), req.attr_d};
		v1 = v0;
		if (v0[0] > v0[1]) begin v1[0] = v0[1]; v1[1] = v0[0]; end
		if (v0[2] > v0[3]) begin v1[2] = v0[3]; v1[3] = v0[2]; end
		v2 = v1;
		if (v1[0] > v1[2]) begin v2[0] = v1[2]; v2[2] = v1[0]; end
		if (v1[1] > v1[3]) begin v2[1] = v1[3]; v2[3] = v1[1]; end
		v3 = v2;
		if (v2[1] > v2[2]) begin v3[1] = v2[2]; v3[2] = v2[1]; end
		for (int i = 0; i < FIELD_ATTRS; i++) begin
			key[i*ATTR_W +: ATTR_W] = v3[i][ATTR_W] ? '0 : v3[i][ATTR_W-1:0];
		end
	end
endmodule
